[hw/rtl/fsc_pkg.sv]
// Shared types and constants for the format specifier checker.
// No dependencies; every other module of the block imports this package.
`timescale 1ns / 1ps

package fsc_pkg;

  localparam int POS_W = 16;
  localparam int LEN_W = 6;
  localparam int KIND_W = 3;

  // Longest text the position counter tracks before it saturates.
  localparam int MAX_TEXT_LEN = 65536;
  localparam int POS_MAX_INT = (MAX_TEXT_LEN - 1 < 65535) ? MAX_TEXT_LEN - 1 : 65535;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(POS_MAX_INT);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_MALFORMED  = 3'd0,
    KIND_PARAMS     = 3'd1,
    KIND_BUGGY_C    = 3'd2,
    KIND_ALWAYS_ONE = 3'd3,
    KIND_FLOAT      = 3'd4,
    KIND_CRASH      = 3'd5
  } kind_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    kind_t            kind;
  } report_t;

  // Up to two reports caused by one input item.
  typedef struct packed {
    logic    two;
    report_t rep0;
    report_t rep1;
  } bundle_t;

endpackage

[hw/rtl/fsc_front.sv]
// Scanner front end: takes one character per item, advances the specifier
// phase and forms the bundle of reports it causes. Depends on fsc_pkg.
`timescale 1ns / 1ps

module fsc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [15:0]      ch,
  input  logic             end_of_text,
  output logic             push,
  output fsc_pkg::bundle_t push_data
);
  import fsc_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_PCT    = 6'b000010,
    PH_FLAGS  = 6'b000100,
    PH_DIGITS = 6'b001000,
    PH_DOT    = 6'b010000,
    PH_FRAC   = 6'b100000
  } phase_t;

  localparam logic [15:0] CH_PCT   = 16'h0025;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_MINUS = 16'h002D;
  localparam logic [15:0] CH_HASH  = 16'h0023;
  localparam logic [15:0] CH_ZERO  = 16'h0030;
  localparam logic [15:0] CH_NINE  = 16'h0039;
  localparam logic [15:0] CH_LA    = 16'h0061;
  localparam logic [15:0] CH_LZ    = 16'h007A;
  localparam logic [15:0] CH_UA    = 16'h0041;
  localparam logic [15:0] CH_UZ    = 16'h005A;

  logic [POS_W-1:0] position_r, position_nxt;
  logic [POS_W-1:0] spec_start_r, spec_start_nxt;
  logic [LEN_W-1:0] spec_len_r, spec_len_nxt;
  phase_t           phase_r, phase_nxt;

  logic             is_pct, is_space, is_dot, is_flag, is_digit, is_letter;
  logic             is_plain;
  kind_t            letter_kind;
  logic             do_fin, do_fail, do_adv;
  phase_t           adv_phase, mid_phase;
  logic [POS_W-1:0] mid_start;
  logic [LEN_W-1:0] len_inc;
  logic             m_vld, e_vld;
  report_t          m_rep, e_rep;

  assign is_pct    = (ch == CH_PCT);
  assign is_space  = (ch == CH_SPACE);
  assign is_dot    = (ch == CH_DOT);
  assign is_flag   = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_HASH) || (ch == CH_ZERO);
  assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_letter = ((ch >= CH_LA) && (ch <= CH_LZ)) || ((ch >= CH_UA) && (ch <= CH_UZ));
  assign len_inc   = (spec_len_r == LEN_MAX) ? LEN_MAX : spec_len_r + LEN_W'(1);

  // Class of the closing letter; plain codes n o p s t get no kind of their own.
  always_comb begin
    is_plain    = 1'b0;
    letter_kind = KIND_MALFORMED;
    case (ch[7:0] & {8{ch[15:8] == 8'h00}})
      "n", "o", "p", "s", "t": is_plain = 1'b1;
      "c": letter_kind = KIND_BUGGY_C;
      "d", "i", "u", "x", "X": letter_kind = KIND_ALWAYS_ONE;
      "a", "A", "e", "E", "f", "F", "g", "G": letter_kind = KIND_FLOAT;
      "S", "Z": letter_kind = KIND_CRASH;
      default: letter_kind = KIND_MALFORMED;
    endcase
  end

  // Decide finish, fail or advance for the character inside a specifier.
  always_comb begin
    do_fin    = 1'b0;
    do_fail   = 1'b0;
    do_adv    = 1'b0;
    adv_phase = phase_r;
    case (phase_r)
      PH_PCT, PH_FLAGS: begin
        if (is_flag) begin
          do_adv = 1'b1; adv_phase = PH_FLAGS;
        end else if (is_digit) begin
          do_adv = 1'b1; adv_phase = PH_DIGITS;
        end else if (is_dot) begin
          do_adv = 1'b1; adv_phase = PH_DOT;
        end else if (is_letter) begin
          do_fin = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          do_adv = 1'b1; adv_phase = PH_DIGITS;
        end else if (is_dot) begin
          do_adv = 1'b1; adv_phase = PH_DOT;
        end else if (is_letter) begin
          do_fin = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_DOT: begin
        if (is_digit) begin
          do_adv = 1'b1; adv_phase = PH_FRAC;
        end else begin
          do_fail = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_letter) do_fin = 1'b1;
        else do_fail = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    mid_phase    = phase_r;
    mid_start    = spec_start_r;
    spec_len_nxt = spec_len_r;
    m_vld        = 1'b0;
    m_rep        = '{pos: spec_start_r, len: LEN_W'(2), kind: KIND_MALFORMED};

    if (phase_r == PH_IDLE) begin
      if (is_pct) begin
        mid_phase    = PH_PCT;
        mid_start    = position_r;
        spec_len_nxt = LEN_W'(1);
      end
    end else if (phase_r == PH_PCT && is_pct) begin
      mid_phase = PH_IDLE;
    end else if (phase_r == PH_PCT && is_space) begin
      m_vld     = 1'b1;
      m_rep.len = LEN_W'(1);
      mid_phase = PH_IDLE;
    end else if (do_fin) begin
      m_rep.len = len_inc;
      if (is_plain) begin
        m_vld      = (len_inc > LEN_W'(2));
        m_rep.kind = KIND_PARAMS;
      end else begin
        m_vld      = 1'b1;
        m_rep.kind = letter_kind;
      end
      mid_phase = PH_IDLE;
    end else if (do_fail) begin
      m_vld     = 1'b1;
      mid_phase = PH_IDLE;
      // A percent that breaks a match opens the next specifier.
      if (phase_r != PH_PCT && is_pct) begin
        mid_phase    = PH_PCT;
        mid_start    = position_r;
        spec_len_nxt = LEN_W'(1);
      end
    end else if (do_adv) begin
      spec_len_nxt = len_inc;
      mid_phase    = adv_phase;
    end

    // End of text closes whatever is still open and rewinds for the next text.
    e_vld = end_of_text && (mid_phase != PH_IDLE);
    e_rep = '{pos: mid_start,
              len: (mid_phase == PH_PCT) ? LEN_W'(1) : LEN_W'(2),
              kind: KIND_MALFORMED};
    if (end_of_text) begin
      phase_nxt      = PH_IDLE;
      position_nxt   = '0;
      spec_start_nxt = '0;
      spec_len_nxt   = '0;
    end else begin
      phase_nxt      = mid_phase;
      position_nxt   = (position_r < POS_MAX) ? position_r + POS_W'(1) : position_r;
      spec_start_nxt = mid_start;
    end
  end

  assign push           = take && (m_vld || e_vld);
  assign push_data.two  = m_vld && e_vld;
  assign push_data.rep0 = m_vld ? m_rep : e_rep;
  assign push_data.rep1 = e_rep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      phase_r      <= PH_IDLE;
      spec_start_r <= '0;
      spec_len_r   <= '0;
    end else if (take) begin
      position_r   <= position_nxt;
      phase_r      <= phase_nxt;
      spec_start_r <= spec_start_nxt;
      spec_len_r   <= spec_len_nxt;
    end
  end

endmodule

[hw/rtl/fsc_queue.sv]
// Small register queue of report bundles between scanner and output stage.
// Depends on fsc_pkg for the bundle type.
`timescale 1ns / 1ps

module fsc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fsc_pkg::bundle_t push_data,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output fsc_pkg::bundle_t head_data
);
  import fsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bundle_t          slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hw/rtl/fsc_back.sv]
// Output stage: unpacks each bundle into one or two result items held in an
// output register. Depends on fsc_pkg.
`timescale 1ns / 1ps

module fsc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  fsc_pkg::bundle_t            head_data,
  output logic                        pop,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [fsc_pkg::POS_W-1:0]   out_issue_pos,
  output logic [fsc_pkg::LEN_W-1:0]   out_code_len,
  output logic [fsc_pkg::KIND_W-1:0]  out_kind,
  output logic                        out_last_of_run
);
  import fsc_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    half_r, half_nxt;
  report_t rep_r;
  logic    last_r;
  logic    load;

  // Load a new item whenever the output register is empty or being taken.
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (half_r || !head_data.two);

  always_comb begin
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      half_nxt      = !half_r && head_data.two;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rep_r  <= half_r ? head_data.rep1 : head_data.rep0;
      last_r <= half_r || !head_data.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      half_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      half_r      <= half_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_issue_pos   = rep_r.pos;
  assign out_code_len    = rep_r.len;
  assign out_kind        = rep_r.kind;
  assign out_last_of_run = last_r;

endmodule

[hw/rtl/format_specifier_checker_core.sv]
// Top level of the printf-style format specifier checker.
// Instantiates fsc_front, fsc_queue and fsc_back; depends on fsc_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one 16-bit text character per item,
//   with in_end_of_text set on the last character of a text. Result channel
//   (out_valid/out_ready): one report per item with the percent position,
//   the code length, the kind and out_last_of_run on the final report that
//   one character caused. A character causes zero, one or two reports.
//   Throughput: one character per cycle while the queue is not full; one
//   report per cycle on the output while the receiver is ready. A character
//   that causes two reports puts them on the output one after the other.
//   A report is written into the queue at the edge that accepts its
//   character, then moves into the output register that drives out_valid.
//   Reset (rst_n low, synchronous) puts the scanner outside any specifier
//   at position 0 and empties the queue and output register.
//   When the receiver stalls, the output register holds its item and the
//   queue absorbs up to QUEUE_DEPTH report bundles; in_ready drops only once
//   the queue is full, so characters that cause no report still flow until
//   then.

module format_specifier_checker_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                in_ch,
  input  logic                       in_end_of_text,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fsc_pkg::POS_W-1:0]  out_issue_pos,
  output logic [fsc_pkg::LEN_W-1:0]  out_code_len,
  output logic [fsc_pkg::KIND_W-1:0] out_kind,
  output logic                       out_last_of_run
);
  import fsc_pkg::*;

  logic    take;
  logic    push, pop, q_full, head_valid;
  bundle_t push_data, head_data;

  // Accept whenever the queue has room for whatever this character causes.
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Scanner: one phase step per accepted character.
  fsc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .ch          (in_ch),
    .end_of_text (in_end_of_text),
    .push        (push),
    .push_data   (push_data)
  );

  // Decouple scanner from the output so each side can stall on its own.
  fsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Drain bundles one report at a time into the output register.
  fsc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_issue_pos   (out_issue_pos),
    .out_code_len    (out_code_len),
    .out_kind        (out_kind),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[dv/format_specifier_checker_core_tb.sv]
// Self-checking testbench for format_specifier_checker_core: directed text table,
// then random texts under several handshake idling patterns and a short closing text.
// Depends on fsc_pkg and format_specifier_checker_core from hw/rtl.
`timescale 1ns / 1ps

module format_specifier_checker_core_tb;
  import fsc_pkg::*;

  // Cycles with no item accepted on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CHARS_PER_PHASE = 150;

  // Idling patterns per random phase: none, sender only, receiver only, both.
  localparam int SENDER_IDLE_PCT [4] = '{0, 86, 0, 13};
  localparam int RECEIVER_STALL_PCT [4] = '{0, 0, 86, 13};

  localparam logic [15:0] CH_PERCENT = 16'h0025;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_DOT = 16'h002E;
  localparam logic [8*4-1:0] FLAG_CHARS = "+-#0";
  localparam logic [8*21-1:0] CODE_LETTERS = "nopstcdiuxXaAeEfFgGSZ";

  // Scanner phases, mirrored from the block's behavior.
  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_PERCENT,
    SCAN_FLAGS,
    SCAN_WIDTH,
    SCAN_DOT,
    SCAN_PRECISION
  } scan_phase_t;

  typedef enum logic [1:0] {
    STEP_FAIL,
    STEP_GROW,
    STEP_CLOSE
  } scan_step_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
    kind_t            kind;
    logic             last;
  } finding_t;

  typedef struct packed {
    logic [15:0] ch;
    logic        eot;
    logic        typed;  // want holds the report this character must cause
    finding_t    want;
  } text_item_t;

  localparam finding_t NO_REPORT = '{16'd0, 6'd0, KIND_MALFORMED, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_ch = 16'd0;
  logic in_end_of_text = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [POS_W-1:0] out_issue_pos;
  logic [LEN_W-1:0] out_code_len;
  logic [KIND_W-1:0] out_kind;
  logic out_last_of_run;

  // Item currently on the input channel, registered alongside the ports.
  text_item_t drv_row = '{16'd0, 1'b0, 1'b0, NO_REPORT};

  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent = 0;
  int mismatches = 0;
  int stuck_cycles = 0;

  // Predicted scanner state.
  logic [POS_W-1:0] scan_pos = '0;
  scan_phase_t scan_phase = SCAN_IDLE;
  logic [POS_W-1:0] open_start = '0;
  logic [LEN_W-1:0] open_len = '0;

  finding_t fresh[$];         // reports caused by the character just scanned
  finding_t findings_due[$];  // reports still awaited from the block

  text_item_t directed_text [28];

  format_specifier_checker_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_issue_pos  (out_issue_pos),
    .out_code_len   (out_code_len),
    .out_kind       (out_kind),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic logic is_digit(input logic [15:0] c);
    return c >= 16'h0030 && c <= 16'h0039;
  endfunction

  function automatic logic is_flag(input logic [15:0] c);
    return c == 16'h002B || c == 16'h002D || c == 16'h0023 || c == 16'h0030;
  endfunction

  function automatic logic is_letter(input logic [15:0] c);
    return (c >= 16'h0061 && c <= 16'h007A) || (c >= 16'h0041 && c <= 16'h005A);
  endfunction

  // Plain codes take no parameters and stay silent when bare.
  function automatic logic is_plain_code(input logic [15:0] c);
    if (c[15:8] != 8'd0) return 1'b0;
    case (c[7:0])
      "n", "o", "p", "s", "t": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic kind_t letter_kind(input logic [15:0] c);
    if (c[15:8] != 8'd0) return KIND_MALFORMED;
    case (c[7:0])
      "c": return KIND_BUGGY_C;
      "d", "i", "u", "x", "X": return KIND_ALWAYS_ONE;
      "a", "A", "e", "E", "f", "F", "g", "G": return KIND_FLOAT;
      "S", "Z": return KIND_CRASH;
      default: return KIND_MALFORMED;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: advance the scanner by one character, leave its reports in fresh
  // ---------------------------------------------------------------------------
  function automatic void add_report(input logic [POS_W-1:0] pos,
                                     input logic [LEN_W-1:0] len, input kind_t kind);
    fresh.insert(fresh.size(), finding_t'{pos, len, kind, 1'b0});
  endfunction

  function automatic void open_spec(input logic [POS_W-1:0] at);
    scan_phase = SCAN_PERCENT;
    open_start = at;
    open_len = 6'd1;
  endfunction

  function automatic logic [LEN_W-1:0] grown_len();
    return (open_len == LEN_MAX) ? LEN_MAX : open_len + LEN_W'(1);
  endfunction

  function automatic void scan_char(input logic [15:0] c, input logic eot);
    logic [POS_W-1:0] here;
    scan_phase_t was;
    scan_phase_t grow_to;
    scan_step_t step;
    here = scan_pos;
    fresh.delete();
    if (scan_pos < POS_MAX) scan_pos = scan_pos + POS_W'(1);

    if (scan_phase == SCAN_IDLE) begin
      if (c == CH_PERCENT) open_spec(here);
    end else if (scan_phase == SCAN_PERCENT && c == CH_PERCENT) begin
      scan_phase = SCAN_IDLE;  // literal percent
    end else if (scan_phase == SCAN_PERCENT && c == CH_SPACE) begin
      add_report(open_start, 6'd1, KIND_MALFORMED);
      scan_phase = SCAN_IDLE;
    end else begin
      was = scan_phase;
      grow_to = scan_phase;
      step = STEP_FAIL;
      case (was)
        SCAN_PERCENT, SCAN_FLAGS: begin
          if (is_flag(c)) begin
            step = STEP_GROW; grow_to = SCAN_FLAGS;
          end else if (is_digit(c)) begin
            step = STEP_GROW; grow_to = SCAN_WIDTH;
          end else if (c == CH_DOT) begin
            step = STEP_GROW; grow_to = SCAN_DOT;
          end else if (is_letter(c)) begin
            step = STEP_CLOSE;
          end
        end
        SCAN_WIDTH: begin
          if (is_digit(c)) begin
            step = STEP_GROW; grow_to = SCAN_WIDTH;
          end else if (c == CH_DOT) begin
            step = STEP_GROW; grow_to = SCAN_DOT;
          end else if (is_letter(c)) begin
            step = STEP_CLOSE;
          end
        end
        SCAN_DOT: begin
          if (is_digit(c)) begin
            step = STEP_GROW; grow_to = SCAN_PRECISION;
          end
        end
        default: begin
          if (is_letter(c)) step = STEP_CLOSE;
        end
      endcase

      case (step)
        STEP_CLOSE: begin
          // Bare plain codes are fine; with parameters they get flagged.
          if (is_plain_code(c)) begin
            if (grown_len() > 6'd2) add_report(open_start, grown_len(), KIND_PARAMS);
          end else begin
            add_report(open_start, grown_len(), letter_kind(c));
          end
          scan_phase = SCAN_IDLE;
        end
        STEP_FAIL: begin
          add_report(open_start, 6'd2, KIND_MALFORMED);
          scan_phase = SCAN_IDLE;
          // A percent that breaks a longer match opens the next specifier.
          if (was != SCAN_PERCENT && c == CH_PERCENT) open_spec(here);
        end
        default: begin
          open_len = grown_len();
          scan_phase = grow_to;
        end
      endcase
    end

    // End of text closes whatever is open and rewinds for the next text.
    if (eot) begin
      if (scan_phase == SCAN_PERCENT) add_report(open_start, 6'd1, KIND_MALFORMED);
      else if (scan_phase != SCAN_IDLE) add_report(open_start, 6'd2, KIND_MALFORMED);
      scan_phase = SCAN_IDLE;
      scan_pos = '0;
      open_start = '0;
      open_len = '0;
    end

    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: predict on input accept, compare on output accept
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin : check_proc
    finding_t due;
    logic moved;
    moved = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      moved = 1'b1;
      scan_char(in_ch, in_end_of_text);
      // Typed rows carry their own answer; keep the predictor in step anyway.
      if (drv_row.typed) findings_due.insert(findings_due.size(), drv_row.want);
      else foreach (fresh[i]) findings_due.insert(findings_due.size(), fresh[i]);
    end
    if (rst_n && out_valid && out_ready) begin
      moved = 1'b1;
      if (findings_due.size() == 0) begin
        note_mismatch($sformatf("unexpected report pos=%0d len=%0d kind=%0d last=%0b",
                                out_issue_pos, out_code_len, out_kind, out_last_of_run));
      end else begin
        due = findings_due.pop_front();
        if (out_issue_pos !== due.pos || out_code_len !== due.len ||
            out_kind !== due.kind || out_last_of_run !== due.last) begin
          note_mismatch($sformatf(
            "expected pos=%0d len=%0d kind=%0d last=%0b, got pos=%0d len=%0d kind=%0d last=%0b",
            due.pos, due.len, due.kind, due.last,
            out_issue_pos, out_code_len, out_kind, out_last_of_run));
        end
      end
    end
    stuck_cycles <= moved ? 0 : stuck_cycles + 1;
  end

  // Receiver: stall at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Hang guard: nothing moving on either channel for too long.
  initial begin
    wait (stuck_cycles >= WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Present one item, idling first at the phase's rate, and hold it until taken.
  task automatic send_row(input text_item_t r);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_ch <= r.ch;
    in_end_of_text <= r.eot;
    drv_row <= r;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_char(input logic [15:0] c, input logic eot);
    text_item_t r;
    r = '{c, eot, 1'b0, NO_REPORT};
    send_row(r);
  endtask

  // Random texts end now and then, often in the middle of a specifier.
  task automatic send_text_char(input logic [15:0] c);
    send_char(c, $urandom_range(39) == 0);
  endtask

  // Drop valid and hold off until every awaited report has come out.
  task automatic wait_for_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (findings_due.size() != 0);
  endtask

  function automatic logic [15:0] pick_digit();
    return 16'h0030 + 16'($urandom_range(9));
  endfunction

  function automatic logic [15:0] pick_flag();
    return {8'd0, FLAG_CHARS[8*$urandom_range(3) +: 8]};
  endfunction

  // Mostly known conversion letters, sometimes any letter at all.
  function automatic logic [15:0] pick_letter();
    if ($urandom_range(3) == 0)
      return ($urandom_range(1) ? 16'h0061 : 16'h0041) + 16'($urandom_range(25));
    return {8'd0, CODE_LETTERS[8*$urandom_range(20) +: 8]};
  endfunction

  function automatic logic [15:0] pick_filler();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(126, 32));
      2: return pick_letter();
      default: return 16'($urandom_range(57, 35));  // punctuation, percent, digits
    endcase
  endfunction

  // One piece of text: filler, a well-formed specifier, a broken one or a
  // percent followed by a space or another percent.
  task automatic random_segment();
    int sel;
    int n;
    sel = $urandom_range(99);
    if (sel < 25) begin
      n = $urandom_range(4, 1);
      repeat (n) send_text_char(pick_filler());
    end else if (sel < 80) begin
      send_text_char(CH_PERCENT);
      n = $urandom_range(2);
      repeat (n) send_text_char(pick_flag());
      // Now and then a long width that can saturate the code length.
      n = ($urandom_range(19) == 0) ? $urandom_range(70, 58) : $urandom_range(2);
      repeat (n) send_text_char(pick_digit());
      if ($urandom_range(2) == 0) begin
        send_text_char(CH_DOT);
        send_text_char(pick_digit());
      end
      send_text_char(pick_letter());
    end else if (sel < 92) begin
      send_text_char(CH_PERCENT);
      n = $urandom_range(3);
      repeat (n) send_text_char($urandom_range(2) == 0 ? CH_DOT
                                : ($urandom_range(1) ? pick_digit() : pick_flag()));
      case ($urandom_range(3))
        0: send_text_char(CH_SPACE);
        1: send_text_char(CH_PERCENT);
        2: send_text_char(CH_DOT);
        default: send_text_char(pick_filler());
      endcase
    end else begin
      send_text_char(CH_PERCENT);
      send_text_char($urandom_range(1) ? CH_SPACE : CH_PERCENT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ph;

    // Directed text. Positions in the comments are those of the percent sign.
    directed_text = '{
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 0: "% "
      '{CH_SPACE,   1'b0, 1'b1, '{16'd0, 6'd1, KIND_MALFORMED, 1'b1}},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 2: "%%"
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 4: "%d"
      '{16'h0064,   1'b0, 1'b1, '{16'd4, 6'd2, KIND_ALWAYS_ONE, 1'b1}},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 6: "%09.5G"
      '{16'h0030,   1'b0, 1'b0, NO_REPORT},
      '{16'h0039,   1'b0, 1'b0, NO_REPORT},
      '{CH_DOT,     1'b0, 1'b0, NO_REPORT},
      '{16'h0035,   1'b0, 1'b0, NO_REPORT},
      '{16'h0047,   1'b0, 1'b0, NO_REPORT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 12: "%7s"
      '{16'h0037,   1'b0, 1'b0, NO_REPORT},
      '{16'h0073,   1'b0, 1'b0, NO_REPORT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 15: "%#" broken
      '{16'h0023,   1'b0, 1'b0, NO_REPORT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 17: "%c"
      '{16'h0063,   1'b0, 1'b0, NO_REPORT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 19: "%." broken,
      '{CH_DOT,     1'b0, 1'b0, NO_REPORT},                                // then lone
      '{CH_PERCENT, 1'b1, 1'b0, NO_REPORT},                                // percent at end
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 0: bare "%p"
      '{16'h0070,   1'b0, 1'b0, NO_REPORT},
      '{CH_PERCENT, 1'b0, 1'b0, NO_REPORT},                                // 2: "%S"
      '{16'h0053,   1'b0, 1'b0, NO_REPORT},
      '{16'hFFFF,   1'b1, 1'b0, NO_REPORT},
      '{CH_PERCENT, 1'b1, 1'b1, '{16'd0, 6'd1, KIND_MALFORMED, 1'b1}}     // 0: lone "%"
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_text[i]) send_row(directed_text[i]);
    wait_for_reports();

    // Random texts under each idling pattern; drain fully between patterns.
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = SENDER_IDLE_PCT[ph];
      stall_pct = RECEIVER_STALL_PCT[ph];
      chars_sent = 0;
      while (chars_sent < CHARS_PER_PHASE) random_segment();
      send_char(pick_filler(), 1'b1);
      wait_for_reports();
    end

    // A short closing text of known specifiers ending in a lone percent.
    idle_pct = 0;
    stall_pct = 0;
    send_char(CH_PERCENT, 1'b0);  // "%d"
    send_char(16'h0064, 1'b0);
    send_char(CH_PERCENT, 1'b0);  // "%5.3x"
    send_char(16'h0035, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(16'h0033, 1'b0);
    send_char(16'h0078, 1'b0);
    send_char(CH_PERCENT, 1'b0);  // "% "
    send_char(CH_SPACE, 1'b0);
    send_char(CH_PERCENT, 1'b1);  // lone percent closing the text
    wait_for_reports();

    // Give stray reports a chance to show up before the verdict.
    repeat (20) @(posedge clk);
    if (mismatches == 0 && findings_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[format_specifier_checker_core.f]
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_front.sv
hw/rtl/fsc_queue.sv
hw/rtl/fsc_back.sv
hw/rtl/format_specifier_checker_core.sv
dv/format_specifier_checker_core_tb.sv
